@@ hw/rtl/sola_pkg.sv @@
`default_nettype none
package sola_pkg;

   localparam int MaxEntries = 64;
   localparam int CountBits  = 16;
   localparam int PosBits    = $clog2(MaxEntries);
   localparam int SizeBits   = 7;
   localparam int CostBits   = 7;
   localparam int KeyBits    = 16;
   localparam int CsrIdxBits = 1;
   localparam int CsrDataBits = 7;

   localparam logic [CsrIdxBits-1:0] CSR_POLICY    = 1'd0;
   localparam logic [CsrIdxBits-1:0] CSR_LIST_SIZE = 1'd1;

   localparam logic [1:0] POL_MTF       = 2'd0;
   localparam logic [1:0] POL_TRANSPOSE = 2'd1;
   localparam logic [1:0] POL_FREQ      = 2'd2;

   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_REINIT = 1'b1;

   typedef struct packed {
      logic               func;
      logic [KeyBits-1:0] key;
   } req_type;

   typedef struct packed {
      logic [CostBits-1:0] cost;
      logic                out_of_range;
   } rsp_type;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_SEARCH = 8'b0000_0100,
      ST_COUNT  = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_SHIFT  = 8'b0010_0000,
      ST_PLACE  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/sola_ram.sv @@
`default_nettype none
module sola_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/self_organizing_list_access.sv @@
// Channel | Direction | Ports                      | Payload
// request | in        | req_valid, req_ready       | req_data  (func, key)
// result  | out       | rsp_valid, rsp_ready       | rsp_data  (cost, out_of_range)
// csr     | in        | csr_we, csr_index          | csr_wdata (policy, list_size)
//
// One request at a time. Every memory access goes through the single read port
// of each RAM: the search reads and compares one entry at a time, the frequency
// policy then bumps the count and scans for the new place, then one shift step
// per moved entry. Out-of-range keys are answered from idle without a search.
// After reset, and after a reinitialize request or list_size write, a clearing
// pass rewrites every entry of both RAMs; no request is taken meanwhile.
// A finished result sits in the output register until taken.
`default_nettype none
module self_organizing_list_access (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire sola_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output sola_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [sola_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire logic [sola_pkg::CsrDataBits-1:0]    csr_wdata
);

   localparam int PB = sola_pkg::PosBits;
   localparam int CB = sola_pkg::CountBits;
   localparam int NB = PB + 1;

   sola_pkg::state_type state_ff, state_in;
   logic [1:0]                       policy_ff, policy_in;
   logic [sola_pkg::SizeBits-1:0]    size_ff, size_in;
   logic                             clr_req_ff, clr_req_in;
   logic [NB-1:0]                    ptr_ff, ptr_in;   // walking position
   logic [NB-1:0]                    pos_ff, pos_in;   // found position
   logic [NB-1:0]                    dst_ff, dst_in;   // target position
   logic [PB-1:0]                    idx_ff, idx_in;
   logic [CB-1:0]                    cnt_ff, cnt_in;
   logic                             phase_ff, phase_in; // 0 issue read, 1 use data
   logic                             rsp_valid_ff, rsp_valid_in;
   sola_pkg::rsp_type                rsp_ff, rsp_in;

   logic          ord_we, cnt_we;
   logic [PB-1:0] ord_waddr, ord_raddr, cnt_waddr, cnt_raddr;
   logic [PB-1:0] ord_wdata, ord_rdata;
   logic [CB-1:0] cnt_wdata, cnt_rdata;

   logic [NB-1:0] n_eff;
   logic [sola_pkg::KeyBits-1:0] key_m1;

   sola_ram #(.Width(PB), .Depth(sola_pkg::MaxEntries)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_waddr), .wr_data(ord_wdata),
      .rd_addr(ord_raddr), .rd_data(ord_rdata)
   );
   sola_ram #(.Width(CB), .Depth(sola_pkg::MaxEntries)) u_count (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   assign n_eff = (size_ff > sola_pkg::SizeBits'(sola_pkg::MaxEntries))
                ? NB'(sola_pkg::MaxEntries) : NB'(size_ff);
   assign key_m1 = req_data.key - 1'b1;

   assign req_ready = (state_ff == sola_pkg::ST_IDLE) && !rsp_valid_ff && !clr_req_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff; policy_in = policy_ff; size_in = size_ff;
      clr_req_in = clr_req_ff; ptr_in = ptr_ff; pos_in = pos_ff; dst_in = dst_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; phase_in = phase_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      ord_we = 1'b0; ord_waddr = ptr_ff[PB-1:0]; ord_wdata = ptr_ff[PB-1:0];
      ord_raddr = ptr_ff[PB-1:0];
      cnt_we = 1'b0; cnt_waddr = ptr_ff[PB-1:0]; cnt_wdata = '0;
      cnt_raddr = idx_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_we) begin
         case (csr_index)
            sola_pkg::CSR_POLICY:    policy_in = csr_wdata[1:0];
            sola_pkg::CSR_LIST_SIZE: begin
               size_in = csr_wdata[sola_pkg::SizeBits-1:0];
               clr_req_in = 1'b1;
            end
            default: ;
         endcase
      end

      case (state_ff)
         sola_pkg::ST_IDLE: begin
            if (clr_req_ff) begin
               clr_req_in = 1'b0; ptr_in = '0; state_in = sola_pkg::ST_CLEAR;
            end else if (req_valid && req_ready) begin
               if (req_data.func == sola_pkg::FUNC_REINIT) begin
                  rsp_in = '{cost: '0, out_of_range: 1'b0};
                  rsp_valid_in = 1'b1; ptr_in = '0; state_in = sola_pkg::ST_CLEAR;
               end else if (req_data.key == '0 ||
                            req_data.key > sola_pkg::KeyBits'(n_eff)) begin
                  rsp_in = '{cost: sola_pkg::CostBits'(n_eff), out_of_range: 1'b1};
                  rsp_valid_in = 1'b1;
               end else begin
                  idx_in = key_m1[PB-1:0]; ptr_in = '0; phase_in = 1'b0;
                  state_in = sola_pkg::ST_SEARCH;
               end
            end
         end
         sola_pkg::ST_CLEAR: begin
            ord_we = 1'b1; cnt_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == NB'(sola_pkg::MaxEntries - 1)) state_in = sola_pkg::ST_IDLE;
         end
         sola_pkg::ST_SEARCH: begin
            if (!phase_ff) phase_in = 1'b1;
            else if (ord_rdata == idx_ff) begin
               pos_in = ptr_ff; phase_in = 1'b0;
               case (policy_ff)
                  sola_pkg::POL_TRANSPOSE: begin
                     if (ptr_ff == '0) begin
                        rsp_in = '{cost: sola_pkg::CostBits'(1), out_of_range: 1'b0};
                        rsp_valid_in = 1'b1; state_in = sola_pkg::ST_IDLE;
                     end else begin
                        rsp_in = '{cost: sola_pkg::CostBits'(ptr_ff + 2'd2),
                                   out_of_range: 1'b0};
                        dst_in = ptr_ff - 1'b1; state_in = sola_pkg::ST_SHIFT;
                     end
                  end
                  sola_pkg::POL_FREQ: begin
                     rsp_in = '{cost: sola_pkg::CostBits'(ptr_ff + 1'b1),
                                out_of_range: 1'b0};
                     state_in = sola_pkg::ST_COUNT;
                  end
                  default: begin
                     rsp_in = '{cost: sola_pkg::CostBits'(ptr_ff + 1'b1),
                                out_of_range: 1'b0};
                     dst_in = '0; state_in = sola_pkg::ST_SHIFT;
                  end
               endcase
            end else begin
               ptr_in = ptr_ff + 1'b1; phase_in = 1'b0;
            end
         end
         sola_pkg::ST_COUNT: begin
            // Read own count, saturating increment, write back
            if (!phase_ff) phase_in = 1'b1;
            else begin
               cnt_in = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
               cnt_we = 1'b1; cnt_waddr = idx_ff; cnt_wdata = cnt_in;
               ptr_in = '0; phase_in = 1'b0; state_in = sola_pkg::ST_SCAN;
            end
         end
         sola_pkg::ST_SCAN: begin
            // Find first position whose count is not greater than ours
            if (ptr_ff == pos_ff) begin
               dst_in = pos_ff; state_in = sola_pkg::ST_SHIFT; phase_in = 1'b0;
            end else begin
               cnt_raddr = ord_rdata;
               ord_raddr = ptr_ff[PB-1:0];
               case (phase_ff)
                  1'b0: phase_in = 1'b1;
                  default: begin
                     // phase 1: order data ready, read count next
                     phase_in = 1'b0;
                     ptr_in = ptr_ff; state_in = sola_pkg::ST_PLACE;
                  end
               endcase
            end
         end
         sola_pkg::ST_PLACE: begin
            // count of order_store[ptr] now valid
            if (!(cnt_rdata > cnt_ff)) begin
               dst_in = ptr_ff; state_in = sola_pkg::ST_SHIFT;
            end else begin
               ptr_in = ptr_ff + 1'b1; state_in = sola_pkg::ST_SCAN;
            end
            phase_in = 1'b0;
         end
         sola_pkg::ST_SHIFT: begin
            // Walk ptr from pos down to dst copying predecessor upward
            if (pos_ff == dst_ff) begin
               state_in = sola_pkg::ST_DONE;
            end else if (!phase_ff) begin
               ptr_in = pos_ff; ord_raddr = pos_ff[PB-1:0] - 1'b1; phase_in = 1'b1;
            end else begin
               ord_we = 1'b1; ord_waddr = ptr_ff[PB-1:0]; ord_wdata = ord_rdata;
               pos_in = pos_ff - 1'b1; phase_in = 1'b0;
            end
         end
         sola_pkg::ST_DONE: begin
            ord_we = 1'b1; ord_waddr = dst_ff[PB-1:0]; ord_wdata = idx_ff;
            rsp_valid_in = 1'b1; state_in = sola_pkg::ST_IDLE;
         end
         default: state_in = sola_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sola_pkg::ST_CLEAR; policy_ff <= sola_pkg::POL_MTF;
         size_ff <= sola_pkg::SizeBits'(64); clr_req_ff <= 1'b0;
         ptr_ff <= '0; phase_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; policy_ff <= policy_in; size_ff <= size_in;
         clr_req_ff <= clr_req_in; ptr_ff <= ptr_in; phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in; dst_ff <= dst_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   // Checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sola_pkg::ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");
   a_oor_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> rsp_data.cost <= 7'd64)
      else $error("bad out-of-range cost");

endmodule
`default_nettype wire
